>>> rtl/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

  localparam int unsigned AddrW         = 32;
  localparam int unsigned SlotsPerBatch = 8;
  localparam int unsigned SlotBits      = 3;  // log2 of slots per batch
  localparam int unsigned SlotByteBits  = 3;  // log2 of bytes per slot
  localparam int unsigned RegionBits    = SlotBits + SlotByteBits;
  localparam int unsigned DefMaxBatches = 16;

  localparam logic [SlotsPerBatch-1:0] AllFree = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OUT_OF_SLOTS = 3'd1,
    ST_DOUBLE_FREE  = 3'd2,
    ST_UNALIGNED    = 3'd3,
    ST_NOT_MANAGED  = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

endpackage

`default_nettype wire

>>> rtl/bitmap_slot_allocator_core.sv
`default_nettype none

// Channel   Direction  Ports                                    Beat taken when
// command   in         start, busy, func_i, address_i           start && !busy
// result    out        done_o, slot_address_o, status_o,        done_o (one cycle)
//                      batch_added_o
// config    in         cfg_we_i, cfg_wdata_i                    cfg_we_i
//
// A command beat is registered and decoded against the free map in the next cycle; its
// result shows on the result ports after the following edge, where it is taken.
// One command per cycle is sustained; busy never rises.
// The free map and batch count update at the result register edge, so the next
// command always sees them. Reset (rst_ni low) frees every slot and activates
// batch 0. The receiver cannot stall; each result is shown for exactly one cycle.

module bitmap_slot_allocator_core import bsa_pkg::*; #(
  parameter int unsigned MaxBatches = DefMaxBatches
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             func_i,
  input  logic [AddrW-1:0] address_i,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  output logic             done_o,
  output logic [AddrW-1:0] slot_address_o,
  output logic [2:0]       status_o,
  output logic             batch_added_o
);

  localparam int unsigned BW = (MaxBatches > 1) ? $clog2(MaxBatches) : 1;
  localparam int unsigned AW = $clog2(MaxBatches + 1);

  logic                                     in_valid_q;
  func_e                                    func_q;
  logic [AddrW-1:0]                         addr_q;
  logic [AddrW-1:0]                         base_q;
  logic [MaxBatches-1:0][SlotsPerBatch-1:0] map_q, map_d;
  logic [AW-1:0]                            active_q, active_d;
  logic                                     done_q;
  logic [AddrW-1:0]                         slot_addr_q, slot_addr_d;
  status_e                                  status_q, status_d;
  logic                                     added_q, added_d;

  logic                alloc_found;
  logic [BW-1:0]       alloc_batch;
  logic [SlotBits-1:0] alloc_slot;
  status_e             free_status;
  logic [BW-1:0]       free_batch;
  logic [SlotBits-1:0] free_slot;
  logic [BW-1:0]       next_batch;

  assign busy = 1'b0;

  bsa_alloc_pick #(
    .MaxBatches(MaxBatches)
  ) u_pick (
    .map_i   (map_q),
    .active_i(active_q),
    .found_o (alloc_found),
    .batch_o (alloc_batch),
    .slot_o  (alloc_slot)
  );

  bsa_free_decode #(
    .MaxBatches(MaxBatches)
  ) u_free (
    .address_i(addr_q),
    .base_i   (base_q),
    .active_i (active_q),
    .map_i    (map_q),
    .status_o (free_status),
    .batch_o  (free_batch),
    .slot_o   (free_slot)
  );

  assign next_batch = active_q[BW-1:0];

  always_comb begin
    map_d       = map_q;
    active_d    = active_q;
    slot_addr_d = '0;
    status_d    = ST_OK;
    added_d     = 1'b0;
    if (in_valid_q) begin
      if (func_q == FUNC_ALLOC) begin
        if (alloc_found) begin
          map_d[alloc_batch][alloc_slot] = 1'b0;
          slot_addr_d = base_q + AddrW'({alloc_batch, alloc_slot, SlotByteBits'(0)});
        end else if (active_q < AW'(MaxBatches)) begin
          // Open the next batch and hand out its first slot.
          map_d[next_batch] = AllFree & ~SlotsPerBatch'(1);
          active_d    = active_q + AW'(1);
          slot_addr_d = base_q + AddrW'({next_batch, SlotBits'(0), SlotByteBits'(0)});
          added_d     = 1'b1;
        end else begin
          status_d = ST_OUT_OF_SLOTS;
        end
      end else begin
        status_d = free_status;
        if (free_status == ST_OK) begin
          map_d[free_batch][free_slot] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      base_q     <= '0;
      map_q      <= {MaxBatches{AllFree}};
      active_q   <= AW'(1);
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      map_q    <= map_d;
      active_q <= active_d;
      done_q   <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_e'(func_i);
      addr_q <= address_i;
    end
    slot_addr_q <= slot_addr_d;
    status_q    <= status_d;
    added_q     <= added_d;
  end

  assign done_o         = done_q;
  assign slot_address_o = slot_addr_q;
  assign status_o       = status_q;
  assign batch_added_o  = added_q && done_q;

  // The active batch count stays between one and the pool size.
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q >= AW'(1)) && (active_q <= AW'(MaxBatches)))
    else $error("active batch count out of range");

  // Every accepted command beat produces its result on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result missing for accepted command");

  // A newly opened batch is always reported as a successful allocation.
  a_added_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_added_o |-> (done_o && (status_o == ST_OK)))
    else $error("batch added without a successful allocation");

  // The batch count only moves together with a batch_added result.
  a_active_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q != $past(active_q)) |-> (batch_added_o && (active_q == $past(active_q) + AW'(1))))
    else $error("active batch count changed unexpectedly");

endmodule

`default_nettype wire

>>> rtl/bsa_alloc_pick.sv
`default_nettype none

module bsa_alloc_pick import bsa_pkg::*; #(
  parameter int unsigned MaxBatches = DefMaxBatches,
  localparam int unsigned BW = (MaxBatches > 1) ? $clog2(MaxBatches) : 1,
  localparam int unsigned AW = $clog2(MaxBatches + 1)
) (
  input  logic [MaxBatches-1:0][SlotsPerBatch-1:0] map_i,
  input  logic [AW-1:0]                            active_i,
  output logic                                     found_o,
  output logic [BW-1:0]                            batch_o,
  output logic [SlotBits-1:0]                      slot_o
);

  logic [MaxBatches-1:0]    has_free;
  logic [MaxBatches-1:0]    low_batch_oh;
  logic [SlotsPerBatch-1:0] sel_row;
  logic [SlotsPerBatch-1:0] first_slot;

  // Lowest set bit is isolated as x & -x, then the one-hot word is OR-encoded.
  always_comb begin
    for (int b = 0; b < MaxBatches; b++) begin
      has_free[b] = (|map_i[b]) && (AW'(b) < active_i);
    end
    low_batch_oh = has_free & (~has_free + MaxBatches'(1));
    batch_o = '0;
    sel_row = '0;
    for (int b = 0; b < MaxBatches; b++) begin
      if (low_batch_oh[b]) begin
        batch_o = batch_o | BW'(b);
        sel_row = sel_row | map_i[b];
      end
    end
    first_slot = sel_row & (~sel_row + SlotsPerBatch'(1));
    slot_o = '0;
    for (int s = 0; s < SlotsPerBatch; s++) begin
      if (first_slot[s]) begin
        slot_o = slot_o | SlotBits'(s);
      end
    end
    found_o = |has_free;
  end

endmodule

`default_nettype wire

>>> rtl/bsa_free_decode.sv
`default_nettype none

module bsa_free_decode import bsa_pkg::*; #(
  parameter int unsigned MaxBatches = DefMaxBatches,
  localparam int unsigned BW = (MaxBatches > 1) ? $clog2(MaxBatches) : 1,
  localparam int unsigned AW = $clog2(MaxBatches + 1)
) (
  input  logic [AddrW-1:0]                         address_i,
  input  logic [AddrW-1:0]                         base_i,
  input  logic [AW-1:0]                            active_i,
  input  logic [MaxBatches-1:0][SlotsPerBatch-1:0] map_i,
  output status_e                                  status_o,
  output logic [BW-1:0]                            batch_o,
  output logic [SlotBits-1:0]                      slot_o
);

  logic [AddrW-1:0]         offset;
  logic [AW+RegionBits-1:0] span;
  logic                     not_managed;
  logic [SlotsPerBatch-1:0] row;

  // Offset wraps modulo 2^32, so addresses below the base land far above the span.
  always_comb begin
    offset      = address_i - base_i;
    span        = {active_i, RegionBits'(0)};
    not_managed = (|offset[AddrW-1:AW+RegionBits]) || (offset[AW+RegionBits-1:0] >= span);
    batch_o     = offset[RegionBits +: BW];
    slot_o      = offset[SlotByteBits +: SlotBits];
    row         = map_i[batch_o];
    if (not_managed) begin
      status_o = ST_NOT_MANAGED;
    end else if (|offset[SlotByteBits-1:0]) begin
      status_o = ST_UNALIGNED;
    end else if (row[slot_o]) begin
      status_o = ST_DOUBLE_FREE;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> test/bitmap_slot_allocator_core_tb.sv
`default_nettype none

module bitmap_slot_allocator_core_tb;
  import bsa_pkg::*;

  localparam int unsigned MaxBatches  = DefMaxBatches;
  localparam int unsigned SlotBytes   = 8;
  localparam int unsigned BatchBytes  = SlotsPerBatch * SlotBytes;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 165;

  typedef struct packed {
    logic [AddrW-1:0] slot_address;
    status_e          status;
    logic             batch_added;
  } outcome_t;

  class slot_alloc_scoreboard;
    logic [AddrW-1:0]         pool_base;
    logic [SlotsPerBatch-1:0] free_map [MaxBatches];
    int unsigned              active_batches;
    outcome_t                 pending_outcomes [$];
    int unsigned              mismatch_count;

    function new();
      pool_base = '0;
      for (int b = 0; b < MaxBatches; b++) free_map[b] = AllFree;
      active_batches = 1;
      mismatch_count = 0;
    endfunction

    function logic [AddrW-1:0] slot_byte_address(int unsigned idx);
      return pool_base + AddrW'(idx * SlotBytes);
    endfunction

    // Random slot inside the active batches that is taken (or free); -1 if none.
    function int pick_slot(bit want_taken);
      int unsigned span;
      int unsigned first;
      int unsigned idx;
      int          found;
      span  = active_batches * SlotsPerBatch;
      first = $urandom_range(span - 1);
      found = -1;
      for (int unsigned i = 0; i < span; i++) begin
        idx = (first + i) % span;
        if (found < 0 &&
            ((free_map[idx / SlotsPerBatch][idx % SlotsPerBatch] == 1'b0) == want_taken))
          found = int'(idx);
      end
      return found;
    endfunction

    function outcome_t predict_outcome(func_e f, logic [AddrW-1:0] addr);
      outcome_t         o;
      logic [AddrW-1:0] offset;
      int unsigned      idx;
      bit               found;
      o.slot_address = '0;
      o.status       = ST_OK;
      o.batch_added  = 1'b0;
      if (f == FUNC_ALLOC) begin
        found = 1'b0;
        for (int unsigned b = 0; b < active_batches; b++) begin
          for (int unsigned s = 0; s < SlotsPerBatch; s++) begin
            if (!found && free_map[b][s]) begin
              free_map[b][s] = 1'b0;
              o.slot_address = slot_byte_address(b * SlotsPerBatch + s);
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          if (active_batches < MaxBatches) begin
            free_map[active_batches] = AllFree & ~SlotsPerBatch'(1);
            o.slot_address = slot_byte_address(active_batches * SlotsPerBatch);
            o.batch_added  = 1'b1;
            active_batches++;
          end else begin
            o.status = ST_OUT_OF_SLOTS;
          end
        end
      end else begin
        // The offset wraps modulo 2^32, so addresses below the base land far out.
        offset = addr - pool_base;
        if (offset >= AddrW'(active_batches * BatchBytes)) begin
          o.status = ST_NOT_MANAGED;
        end else if (offset[SlotByteBits-1:0] != '0) begin
          o.status = ST_UNALIGNED;
        end else begin
          idx = offset >> SlotByteBits;
          if (free_map[idx / SlotsPerBatch][idx % SlotsPerBatch]) begin
            o.status = ST_DOUBLE_FREE;
          end else begin
            free_map[idx / SlotsPerBatch][idx % SlotsPerBatch] = 1'b1;
          end
        end
      end
      return o;
    endfunction

    function void note_command(func_e f, logic [AddrW-1:0] addr);
      pending_outcomes.push_back(predict_outcome(f, addr));
    endfunction

    task report_mismatch(string what, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatch_count++;
    endtask

    task check_result(logic [AddrW-1:0] slot_address, logic [2:0] status,
                      logic batch_added);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result beat, slot_address", slot_address, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (slot_address !== want.slot_address)
          report_mismatch("slot_address", slot_address, want.slot_address);
        if (status !== want.status)
          report_mismatch("status", AddrW'(status), AddrW'(want.status));
        if (batch_added !== want.batch_added)
          report_mismatch("batch_added", AddrW'(batch_added), AddrW'(want.batch_added));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             func = FUNC_ALLOC;
  logic [AddrW-1:0] address = '0;
  logic             cfg_we = 1'b0;
  logic [AddrW-1:0] cfg_wdata = '0;
  logic             done_o;
  logic [AddrW-1:0] slot_address_o;
  logic [2:0]       status_o;
  logic             batch_added_o;

  slot_alloc_scoreboard sb;
  int unsigned          stall_cycles = 0;

  bitmap_slot_allocator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func),
    .address_i      (address),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .done_o         (done_o),
    .slot_address_o (slot_address_o),
    .status_o       (status_o),
    .batch_added_o  (batch_added_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (done_o) sb.check_result(slot_address_o, status_o, batch_added_o);
    if (start && !busy) sb.note_command(func_e'(func), address);
    if (cfg_we) sb.pool_base = cfg_wdata;
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (stall_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Keeps start high across back-to-back beats; an idle cycle lowers it.
  task send_command(func_e f, logic [AddrW-1:0] a);
    @(negedge clk_i);
    start   <= 1'b1;
    func    <= f;
    address <= a;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start   <= 1'b0;
      address <= $urandom;
      func    <= 1'($urandom_range(1));
    end
  endtask

  task wait_drained();
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task write_pool_base(logic [AddrW-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task send_random_free();
    int          pick;
    int unsigned roll;
    logic [AddrW-1:0] a;
    roll = $urandom_range(99);
    a    = $urandom;
    if (roll < 65) begin
      pick = sb.pick_slot(1'b1);
      if (pick < 0) pick = sb.pick_slot(1'b0);
      a = sb.slot_byte_address(pick);
    end else if (roll < 78) begin
      pick = sb.pick_slot(1'b0);
      if (pick < 0) pick = sb.pick_slot(1'b1);
      a = sb.slot_byte_address(pick);
    end else if (roll < 86) begin
      pick = $urandom_range(sb.active_batches * SlotsPerBatch - 1);
      a = sb.slot_byte_address(pick) + AddrW'($urandom_range(1, SlotBytes - 1));
    end else if (roll < 93) begin
      a = sb.pool_base + AddrW'(sb.active_batches * BatchBytes) +
          AddrW'($urandom_range(0, 4095));
    end
    send_command(FUNC_FREE, a);
  endtask

  initial begin
    logic [AddrW-1:0] phase_base [NumPhases];
    int unsigned      alloc_pct  [NumPhases];
    int unsigned      burst_left;

    sb = new();
    phase_base = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
                   32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    phase_base[3] = $urandom;
    phase_base[4] = $urandom & ~32'h7;
    phase_base[5] = $urandom;
    alloc_pct = '{80, 50, 92, 30, 70, 60};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every slot starts free, so the first free is a double free.
    send_command(FUNC_FREE, 32'h0);
    send_command(FUNC_ALLOC, 32'hFFFF_FFFF);
    send_command(FUNC_FREE, 32'h0);
    send_command(FUNC_FREE, 32'h0);
    send_command(FUNC_FREE, 32'h4);
    send_command(FUNC_FREE, 32'h40);
    send_command(FUNC_FREE, 32'hFFFF_FFFF);
    repeat (9) send_command(FUNC_ALLOC, 32'h0);
    send_command(FUNC_FREE, 32'h7F);
    send_command(FUNC_FREE, 32'h38);
    send_command(FUNC_FREE, 32'h80);
    idle_cycles(1);

    // A base near the top of the address space makes slot addresses wrap.
    write_pool_base(32'hFFFF_FFF8);
    send_command(FUNC_ALLOC, 32'h0);
    send_command(FUNC_FREE, 32'h0000_0000);
    send_command(FUNC_FREE, 32'hFFFF_FFF0);
    send_command(FUNC_FREE, 32'hFFFF_FFF8);

    burst_left = 0;
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_pool_base(phase_base[p]);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(3))
            0: idle_cycles(0);
            1: idle_cycles($urandom_range(1, 2));
            2: idle_cycles($urandom_range(1, 6));
            default: idle_cycles($urandom_range(3, 20));
          endcase
        end
        burst_left--;
        if ($urandom_range(99) < alloc_pct[p]) send_command(FUNC_ALLOC, $urandom);
        else send_random_free();
      end
    end

    idle_cycles(1);
    wait_drained();
    if (sb.mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/bsa_pkg.sv
rtl/bsa_alloc_pick.sv
rtl/bsa_free_decode.sv
rtl/bitmap_slot_allocator_core.sv
test/bitmap_slot_allocator_core_tb.sv
